[rtl/core/paca_pkg.sv]
// Shared constants, payload types and codes for the patch affine color block.
package paca_pkg;

    localparam int MAX_PATCH_ROWS = 64;
    localparam int MAX_PATCH_COLS = 64;
    localparam int CHANNELS       = 3;
    localparam int PAIRS          = CHANNELS * CHANNELS;
    localparam int PAIR_W         = $clog2(PAIRS);
    localparam int BANK_DEPTH     = MAX_PATCH_ROWS * MAX_PATCH_COLS;
    localparam int BANK_AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam int POS_W   = 12;
    localparam int FEAT_W  = 16;
    localparam int COEF_W  = 24;
    localparam int SPAN_W  = 25;
    localparam int LEVEL_W = 8;
    localparam int SHIFT_W = 3;

    localparam logic [SHIFT_W-1:0] PATCH_SHIFT_RST = 3'd4;

    // result queue; depth is a power of two so the pointers wrap on their own
    localparam int OUT_FIFO_DEPTH = 16;
    localparam int FIFO_AW        = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CW        = FIFO_AW + 1;

    localparam logic [1:0] CMD_RANGE = 2'd0;
    localparam logic [1:0] CMD_COEF  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic [1:0]                in_channel;
        logic [1:0]                out_channel;
        logic [LEVEL_W-1:0]        level;
        logic signed [COEF_W-1:0]  range_min;
        logic signed [COEF_W-1:0]  range_max;
        logic signed [FEAT_W-1:0]  feat_0;
        logic signed [FEAT_W-1:0]  feat_1;
        logic signed [FEAT_W-1:0]  feat_2;
    } in_item_t;

    typedef struct packed {
        logic signed [FEAT_W-1:0]  out_0;
        logic signed [FEAT_W-1:0]  out_1;
        logic signed [FEAT_W-1:0]  out_2;
        logic                      clipped;
        logic                      bad_patch;
    } out_item_t;

    // coefficient bank access issued by the load pipeline: one write or one read per cycle
    typedef struct packed {
        logic                      we;
        logic                      rd;
        logic [PAIR_W-1:0]         pair;
        logic [BANK_AW-1:0]        addr;
        logic signed [COEF_W-1:0]  coef;
        logic                      bad;
        logic signed [FEAT_W-1:0]  feat_0;
        logic signed [FEAT_W-1:0]  feat_1;
        logic signed [FEAT_W-1:0]  feat_2;
    } mem_req_t;

endpackage

[rtl/core/patch_affine_color_apply.sv]
// Top level: per-patch 3x3 color transform over a stream of pixel features.
// A pixel transaction passes dequant stages s1 to s5, the bank read, MAC stages m0 to m2, then the result queue.
// Throughput: one transaction per cycle while item_ready is high; nine coefficient banks give one read per pixel.
// Input is held off only while 16 pixel results are in flight or queued.
// Reset clears pipeline and queue control and sets patch_shift to 4; stores start unwritten.
module patch_affine_color_apply
    import paca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  in_item_t            item,
    output logic                result_valid,
    input  logic                result_ready,
    output out_item_t           result,
    input  logic                cfg_we,
    input  logic [SHIFT_W-1:0]  cfg_wdata
);

    logic                          take;
    logic                          credit_ok;
    mem_req_t                      mem_req;
    logic [PAIRS-1:0][COEF_W-1:0]  coef_bus;
    logic                          res_valid;
    out_item_t                     res;

    assign item_ready = credit_ok;
    assign take       = item_valid && item_ready;

    paca_dequant u_dequant (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (item),
        .mem_req   (mem_req)
    );

    // one bank per channel pair, all read at the same patch address
    for (genvar gk = 0; gk < PAIRS; gk++)
    begin : g_bank
        paca_ram #(
            .WIDTH (COEF_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .clk   (clk),
            .we    (mem_req.we && (mem_req.pair == PAIR_W'(gk))),
            .waddr (mem_req.addr),
            .wdata (mem_req.coef),
            .re    (mem_req.rd),
            .raddr (mem_req.addr),
            .rdata (coef_bus[gk])
        );
    end

    paca_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .mem_req   (mem_req),
        .coef_bus  (coef_bus),
        .res_valid (res_valid),
        .res       (res)
    );

    paca_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_take     (take && (item.cmd == CMD_PIXEL)),
        .credit_ok    (credit_ok),
        .push         (res_valid),
        .push_data    (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/core/paca_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module paca_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/paca_dequant.sv]
// Range tables, coefficient dequantization pipeline and bank access issue.
module paca_dequant
    import paca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SHIFT_W-1:0]  cfg_wdata,
    input  logic                take,
    input  in_item_t            item,
    output mem_req_t            mem_req
);

    localparam int A_BIAS    = 2 ** 17;
    localparam int SPAN_BIAS = 255 * A_BIAS;
    localparam int ONE_Q16   = 65536;
    localparam int COEF_MAX  = 2 ** (COEF_W - 1) - 1;
    localparam int COEF_MIN  = -(2 ** (COEF_W - 1));
    localparam int X_W       = 26;
    localparam int QE_W      = 19;
    localparam int REM_W     = 27;
    localparam int LA_W      = 28;
    localparam int T_W       = 16;
    localparam int SUM_W     = 29;
    localparam logic [24:0] RECIP = 25'h1010101;

    typedef struct packed {
        logic [LEVEL_W-1:0]        level;
        logic signed [COEF_W-1:0]  cmin;
        logic [PAIR_W-1:0]         pair;
        logic [BANK_AW-1:0]        addr;
        logic                      bad;
        logic signed [FEAT_W-1:0]  feat_0;
        logic signed [FEAT_W-1:0]  feat_1;
        logic signed [FEAT_W-1:0]  feat_2;
    } carry_t;

    function automatic logic [BANK_AW-1:0] patch_addr(input logic [POS_W-1:0] prow,
                                                      input logic [POS_W-1:0] pcol);
        logic [23:0] lin;
        lin = 24'(prow) * 24'(MAX_PATCH_COLS) + 24'(pcol);
        return lin[BANK_AW-1:0];
    endfunction

    logic [SHIFT_W-1:0]        patch_shift_reg;
    logic signed [COEF_W-1:0]  min_tab_reg [PAIRS];
    logic signed [SPAN_W-1:0]  span_tab_reg [PAIRS];

    logic                      ch_ok;
    logic                      range_take;
    logic                      coef_take;
    logic                      pix_take;
    logic [PAIR_W-1:0]         pair_raw;
    logic [PAIR_W-1:0]         pair_idx;
    logic [POS_W-1:0]          prow;
    logic [POS_W-1:0]          pcol;
    logic signed [SPAN_W-1:0]  span_eff;
    logic [X_W-1:0]            x_next;
    carry_t                    carry_next;

    logic                      s1_coef_v_reg, s2_coef_v_reg, s3_coef_v_reg;
    logic                      s4_coef_v_reg, s5_coef_v_reg;
    logic                      s1_pix_v_reg, s2_pix_v_reg, s3_pix_v_reg;
    logic                      s4_pix_v_reg, s5_pix_v_reg;
    carry_t                    s1_carry_reg, s2_carry_reg, s3_carry_reg;
    carry_t                    s4_carry_reg, s5_carry_reg;

    logic [X_W-1:0]            s1_x_reg;
    logic [X_W-1:0]            s2_x_reg;
    logic [QE_W-1:0]           s2_qe_reg;
    logic signed [QE_W-1:0]    s3_a_reg;
    logic [7:0]                s3_b_reg;
    logic signed [LA_W-1:0]    s4_la_reg;
    logic [T_W-1:0]            s4_t_reg;
    logic signed [LA_W-1:0]    s5_q_reg;

    logic [50:0]               recip_prod;
    logic [QE_W-1:0]           qe_next;
    logic [REM_W-1:0]          qe_x255;
    logic [REM_W-1:0]          rem;
    logic [QE_W-1:0]           ab;
    logic signed [QE_W-1:0]    a_next;
    logic [7:0]                b_next;
    logic signed [LEVEL_W:0]   level_s;
    logic signed [LA_W-1:0]    la_next;
    logic [T_W-1:0]            t_next;
    logic [23:0]               t_x257;
    logic [7:0]                q2e;
    logic [16:0]               rem2;
    logic [7:0]                q2;
    logic signed [LA_W-1:0]    q_next;
    logic signed [SUM_W-1:0]   csum;
    logic signed [COEF_W-1:0]  coef_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_shift_reg <= PATCH_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            patch_shift_reg <= cfg_wdata;
        end
    end

    // decode and table lookup
    always_comb
    begin
        pair_raw   = 4'({2'b00, item.in_channel} * 4'd3) + {2'b00, item.out_channel};
        ch_ok      = (item.in_channel < 2'(CHANNELS)) && (item.out_channel < 2'(CHANNELS));
        pair_idx   = ch_ok ? pair_raw[PAIR_W-1:0] : '0;
        range_take = take && (item.cmd == CMD_RANGE) && ch_ok;
        coef_take  = take && (item.cmd == CMD_COEF) && ch_ok
                     && (item.row < POS_W'(MAX_PATCH_ROWS))
                     && (item.col < POS_W'(MAX_PATCH_COLS));
        pix_take   = take && (item.cmd == CMD_PIXEL);

        prow = item.row >> patch_shift_reg;
        pcol = item.col >> patch_shift_reg;

        span_eff = (span_tab_reg[pair_idx] == '0) ? SPAN_W'(ONE_Q16) : span_tab_reg[pair_idx];
        // bias the span by a multiple of 255 so the divide below sees a positive value
        x_next   = X_W'(27'(span_eff) + 27'(SPAN_BIAS));

        carry_next.level  = item.level;
        carry_next.cmin   = min_tab_reg[pair_idx];
        carry_next.pair   = pair_idx;
        carry_next.addr   = (item.cmd == CMD_PIXEL) ? patch_addr(prow, pcol)
                                                    : patch_addr(item.row, item.col);
        carry_next.bad    = (prow >= POS_W'(MAX_PATCH_ROWS)) || (pcol >= POS_W'(MAX_PATCH_COLS));
        carry_next.feat_0 = item.feat_0;
        carry_next.feat_1 = item.feat_1;
        carry_next.feat_2 = item.feat_2;
    end

    always_ff @(posedge clk)
    begin
        if (range_take)
        begin
            min_tab_reg[pair_idx]  <= item.range_min;
            span_tab_reg[pair_idx] <= SPAN_W'(item.range_max) - SPAN_W'(item.range_min);
        end
    end

    // span = 255*a + b: estimate by reciprocal, then one correction step
    always_comb
    begin
        recip_prod = 51'(s1_x_reg) * 51'(RECIP);
        qe_next    = recip_prod[50:32];

        qe_x255 = REM_W'({s2_qe_reg, 8'b0}) - REM_W'(s2_qe_reg);
        rem     = REM_W'(s2_x_reg) - qe_x255;
        if (rem >= REM_W'(255))
        begin
            ab     = s2_qe_reg + QE_W'(1);
            b_next = 8'(rem - REM_W'(255));
        end
        else
        begin
            ab     = s2_qe_reg;
            b_next = rem[7:0];
        end
        a_next = signed'(ab - QE_W'(A_BIAS));
    end

    // level*span/255 rounded = level*a + floor((level*b + 127) / 255)
    always_comb
    begin
        level_s = {1'b0, s3_carry_reg.level};
        la_next = LA_W'(level_s) * LA_W'(s3_a_reg);
        t_next  = {8'b0, s3_carry_reg.level} * {8'b0, s3_b_reg} + T_W'(127);

        t_x257 = {s4_t_reg, 8'b0} + 24'(s4_t_reg);
        q2e    = t_x257[23:16];
        rem2   = 17'(s4_t_reg) - (17'({q2e, 8'b0}) - 17'(q2e));
        q2     = (rem2 >= 17'd255) ? (q2e + 8'd1) : q2e;
        q_next = s4_la_reg + signed'(LA_W'(q2));
    end

    always_comb
    begin
        csum = SUM_W'(s5_carry_reg.cmin) + SUM_W'(s5_q_reg);
        if (csum > SUM_W'(COEF_MAX))
        begin
            coef_sat = COEF_W'(COEF_MAX);
        end
        else if (csum < SUM_W'(COEF_MIN))
        begin
            coef_sat = COEF_W'(COEF_MIN);
        end
        else
        begin
            coef_sat = csum[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_coef_v_reg <= 1'b0;
            s2_coef_v_reg <= 1'b0;
            s3_coef_v_reg <= 1'b0;
            s4_coef_v_reg <= 1'b0;
            s5_coef_v_reg <= 1'b0;
            s1_pix_v_reg  <= 1'b0;
            s2_pix_v_reg  <= 1'b0;
            s3_pix_v_reg  <= 1'b0;
            s4_pix_v_reg  <= 1'b0;
            s5_pix_v_reg  <= 1'b0;
        end
        else
        begin
            s1_coef_v_reg <= coef_take;
            s2_coef_v_reg <= s1_coef_v_reg;
            s3_coef_v_reg <= s2_coef_v_reg;
            s4_coef_v_reg <= s3_coef_v_reg;
            s5_coef_v_reg <= s4_coef_v_reg;
            s1_pix_v_reg  <= pix_take;
            s2_pix_v_reg  <= s1_pix_v_reg;
            s3_pix_v_reg  <= s2_pix_v_reg;
            s4_pix_v_reg  <= s3_pix_v_reg;
            s5_pix_v_reg  <= s4_pix_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_carry_reg <= carry_next;
        s2_carry_reg <= s1_carry_reg;
        s3_carry_reg <= s2_carry_reg;
        s4_carry_reg <= s3_carry_reg;
        s5_carry_reg <= s4_carry_reg;
        s1_x_reg     <= x_next;
        s2_x_reg     <= s1_x_reg;
        s2_qe_reg    <= qe_next;
        s3_a_reg     <= a_next;
        s3_b_reg     <= b_next;
        s4_la_reg    <= la_next;
        s4_t_reg     <= t_next;
        s5_q_reg     <= q_next;
    end

    // writes and pixel reads leave from the same stage, so program order holds at the banks
    always_comb
    begin
        mem_req.we     = s5_coef_v_reg;
        mem_req.rd     = s5_pix_v_reg;
        mem_req.pair   = s5_carry_reg.pair;
        mem_req.addr   = s5_carry_reg.addr;
        mem_req.coef   = coef_sat;
        mem_req.bad    = s5_carry_reg.bad;
        mem_req.feat_0 = s5_carry_reg.feat_0;
        mem_req.feat_1 = s5_carry_reg.feat_1;
        mem_req.feat_2 = s5_carry_reg.feat_2;
    end

`ifndef SYNTHESIS
    a_pix_reaches_banks: assert property (@(posedge clk) disable iff (!rst_n)
        pix_take |-> ##5 mem_req.rd)
        else $error("pixel transaction did not reach the bank read stage");

    a_coef_reaches_banks: assert property (@(posedge clk) disable iff (!rst_n)
        coef_take |-> ##5 (mem_req.we && !mem_req.rd))
        else $error("coefficient load did not reach the bank write stage");
`endif

endmodule

[rtl/core/paca_mac.sv]
// Per-pixel multiply-accumulate of features with the nine patch coefficients.
module paca_mac
    import paca_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  mem_req_t                         mem_req,
    input  logic [PAIRS-1:0][COEF_W-1:0]     coef_bus,
    output logic                             res_valid,
    output out_item_t                        res
);

    localparam int PROD_W     = FEAT_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 16;
    localparam int RND_W      = ACC_W - FRAC_SHIFT;
    localparam int RND_HALF   = 2 ** (FRAC_SHIFT - 1);
    localparam int OUT_MAX    = 2 ** (FEAT_W - 1) - 1;
    localparam int OUT_MIN    = -(2 ** (FEAT_W - 1));

    logic                      m0_v_reg;
    logic                      m0_bad_reg;
    logic signed [FEAT_W-1:0]  m0_feat_reg [CHANNELS];
    logic signed [PROD_W-1:0]  prod_next [PAIRS];

    logic                      m1_v_reg;
    logic                      m1_bad_reg;
    logic signed [PROD_W-1:0]  m1_prod_reg [PAIRS];
    logic signed [ACC_W-1:0]   acc [CHANNELS];

    logic                      m2_v_reg;
    logic                      m2_bad_reg;
    logic signed [RND_W-1:0]   m2_rnd_reg [CHANNELS];
    logic signed [FEAT_W-1:0]  sat_val [CHANNELS];
    logic [CHANNELS-1:0]       hit;

    // bank data arrives in the cycle after the read; hold the pixel alongside it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
        end
        else
        begin
            m0_v_reg <= mem_req.rd;
            m1_v_reg <= m0_v_reg;
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_bad_reg     <= mem_req.bad;
        m0_feat_reg[0] <= mem_req.feat_0;
        m0_feat_reg[1] <= mem_req.feat_1;
        m0_feat_reg[2] <= mem_req.feat_2;
        m1_bad_reg     <= m0_bad_reg;
        m2_bad_reg     <= m1_bad_reg;
    end

    for (genvar gi = 0; gi < CHANNELS; gi++)
    begin : g_in
        for (genvar go = 0; go < CHANNELS; go++)
        begin : g_out
            assign prod_next[gi*CHANNELS+go] = PROD_W'(m0_feat_reg[gi])
                * PROD_W'($signed(coef_bus[gi*CHANNELS+go]));
        end
    end

    always_ff @(posedge clk)
    begin
        m1_prod_reg <= prod_next;
    end

    // Q.28 sum, round half up to Q4.12
    for (genvar go = 0; go < CHANNELS; go++)
    begin : g_acc
        assign acc[go] = ACC_W'(m1_prod_reg[go])
                       + ACC_W'(m1_prod_reg[CHANNELS+go])
                       + ACC_W'(m1_prod_reg[2*CHANNELS+go])
                       + ACC_W'(RND_HALF);

        always_ff @(posedge clk)
        begin
            m2_rnd_reg[go] <= acc[go][ACC_W-1:FRAC_SHIFT];
        end

        assign hit[go]     = (m2_rnd_reg[go] > RND_W'(OUT_MAX)) || (m2_rnd_reg[go] < RND_W'(OUT_MIN));
        assign sat_val[go] = (m2_rnd_reg[go] > RND_W'(OUT_MAX)) ? FEAT_W'(OUT_MAX)
                           : (m2_rnd_reg[go] < RND_W'(OUT_MIN)) ? FEAT_W'(OUT_MIN)
                           : m2_rnd_reg[go][FEAT_W-1:0];
    end

    always_comb
    begin
        res_valid     = m2_v_reg;
        res.out_0     = m2_bad_reg ? '0 : sat_val[0];
        res.out_1     = m2_bad_reg ? '0 : sat_val[1];
        res.out_2     = m2_bad_reg ? '0 : sat_val[2];
        res.clipped   = !m2_bad_reg && (|hit);
        res.bad_patch = m2_bad_reg;
    end

endmodule

[rtl/core/paca_out_fifo.sv]
// Result queue with a pixel credit count whose credit_ok gates all new transactions.
module paca_out_fifo
    import paca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_take,
    output logic       credit_ok,
    input  logic       push,
    input  out_item_t  push_data,
    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result
);

    out_item_t             fifo_mem [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg;
    logic [FIFO_AW-1:0]    rd_ptr_reg;
    logic [FIFO_CW-1:0]    cnt_reg;
    logic [FIFO_CW-1:0]    cnt_next;
    logic [FIFO_CW-1:0]    pend_reg;
    logic [FIFO_CW-1:0]    pend_next;
    logic                  pop;

    always_comb
    begin
        pop          = (cnt_reg != '0) && result_ready;
        result_valid = (cnt_reg != '0);
        result       = fifo_mem[rd_ptr_reg];
        // every pixel in flight owns a slot, so the queue never overflows
        credit_ok    = (pend_reg != FIFO_CW'(OUT_FIFO_DEPTH));
        cnt_next     = cnt_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        pend_next    = pend_reg + FIFO_CW'(pix_take) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pend_reg)
        else $error("queued results exceed pixels in flight");

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= FIFO_CW'(OUT_FIFO_DEPTH))
        else $error("pixels in flight exceed queue depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != FIFO_CW'(OUT_FIFO_DEPTH)) || pop)
        else $error("result pushed into a full queue");
`endif

endmodule
